/* hdl/tssg_pkg.sv */
// Shared constants for the token stream stutter guard.
// Stop reason codes, token id limits, window sizes, config indices, scan phases and sequencer states.
// No dependencies.
package tssg_pkg;

  localparam int HistDepthDef = 80;

  localparam int TokW    = 19;
  localparam int HistW   = 18;
  localparam int CountW  = 13;
  localparam int ReasonW = 4;

  localparam logic [HistW-1:0] SPEECH_LOW  = 18'd151671;
  localparam logic [HistW-1:0] SPEECH_HIGH = 18'd217207;
  localparam logic [HistW-1:0] END_ID_A    = 18'd151643;
  localparam logic [HistW-1:0] END_ID_B    = 18'd151645;
  localparam logic [HistW-1:0] END_ID_C    = 18'd151670;

  localparam logic [2:0] MAX_RUN = 3'd4;
  localparam logic [2:0] RUN_SAT = 3'd7;

  localparam logic [6:0] LOOP_WINDOW       = 7'd12;
  localparam logic [6:0] LOOP_MAX_DISTINCT = 7'd3;
  localparam logic [6:0] DOM_WINDOW        = 7'd30;
  localparam logic [4:0] DOM_LIMIT         = 5'd18;
  localparam logic [6:0] DIV_WINDOW        = 7'd80;
  localparam logic [6:0] DIV_MIN_DISTINCT  = 7'd12;

  localparam logic [ReasonW-1:0] RSN_NONE   = 4'd0;
  localparam logic [ReasonW-1:0] RSN_LENGTH = 4'd1;
  localparam logic [ReasonW-1:0] RSN_NULL   = 4'd2;
  localparam logic [ReasonW-1:0] RSN_END    = 4'd3;
  localparam logic [ReasonW-1:0] RSN_REPEAT = 4'd4;
  localparam logic [ReasonW-1:0] RSN_LOOP   = 4'd5;
  localparam logic [ReasonW-1:0] RSN_DOM    = 4'd6;
  localparam logic [ReasonW-1:0] RSN_DIV    = 4'd7;
  localparam logic [ReasonW-1:0] RSN_OVER   = 4'd8;

  localparam logic [1:0] CFG_PROMPT  = 2'd0;
  localparam logic [1:0] CFG_CONTEXT = 2'd1;
  localparam logic [1:0] CFG_MAXGEN  = 2'd2;

  localparam logic [1:0] PH_LOOP = 2'd0;
  localparam logic [1:0] PH_DOM  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_OUT_RD  = 4'd2;
  localparam logic [3:0] S_OUT_LAT = 4'd3;
  localparam logic [3:0] S_IN_RD   = 4'd4;
  localparam logic [3:0] S_IN_CMP  = 4'd5;
  localparam logic [3:0] S_OUT_END = 4'd6;
  localparam logic [3:0] S_WRITE   = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

endpackage

/* hdl/token_stream_stutter_guard.sv */
// Token stream stutter guard: per-token stop checks over a ring of accepted tokens.
// Depends on tssg_pkg.
//
//  channel | ports                                            | direction
//  in      | in_valid in_stall in_token_id in_vocab_end_flag  | request in
//          | in_new_sequence                                  |
//  out     | out_valid out_stall out_accepted out_stop        | request out
//          | out_stop_reason out_generated_count              |
//  cfg     | cfg_we cfg_index cfg_wdata                       | write only
//
// One request at a time. After the accepting edge an early stop passes S_CHECK and
// S_DONE before out_valid rises; an accept with no window scan passes S_CHECK,
// S_WRITE and S_DONE. The window scans run through one history read port and one
// comparator: S_OUT_RD, S_OUT_LAT and S_OUT_END per outer entry, S_IN_RD and
// S_IN_CMP per compare. rst_n is synchronous; history contents are not cleared.
// in_stall is high while a request is being worked on or a result waits.
module token_stream_stutter_guard
  import tssg_pkg::*;
#(
  parameter int HISTORY_DEPTH = HistDepthDef
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [TokW-1:0]   in_token_id,
  input  logic                     in_vocab_end_flag,
  input  logic                     in_new_sequence,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_accepted,
  output logic                     out_stop,
  output logic [ReasonW-1:0]       out_stop_reason,
  output logic [CountW-1:0]        out_generated_count,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [CountW-1:0]        cfg_wdata
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);

  logic [HistW-1:0] mem [HISTORY_DEPTH];
  logic [HistW-1:0] rdata_r;

  logic [3:0]             state_r;
  logic [11:0]            prompt_r;
  logic [CountW-1:0]      ctx_r, maxg_r, acc_r;
  logic [AW-1:0]          head_r;
  logic signed [TokW-1:0] prev_r, tok_r;
  logic [2:0]             run_r;
  logic                   over_r, endf_r;
  logic [1:0]             ph_r;
  logic [6:0]             i_r, j_r, dcnt_r;
  logic [4:0]             cnt_r;
  logic                   match_r;
  logic [HistW-1:0]       v_r;
  logic                   res_acc_r;
  logic [ReasonW-1:0]     res_rsn_r;
  logic                   out_valid_r, out_acc_r;
  logic [ReasonW-1:0]     out_rsn_r;
  logic [CountW-1:0]      out_cnt_r;

  logic [6:0]   idx, win, dnew;
  logic [AW:0]  addr_sum;
  logic [AW-1:0] rd_addr;
  logic [13:0]  len_sum;
  logic         len_stop, speech, is_end, eq_prev, cmp_eq;
  logic [2:0]   run_nxt;

  function automatic logic [6:0] ph_win(input logic [1:0] p);
    case (p)
      PH_LOOP: ph_win = LOOP_WINDOW;
      PH_DOM:  ph_win = DOM_WINDOW;
      default: ph_win = DIV_WINDOW;
    endcase
  endfunction

  assign win = ph_win(ph_r);
  assign idx = (state_r == S_OUT_RD) ? i_r : j_r;
  assign addr_sum = {1'b0, head_r} + DEPTH_W - (AW+1)'(1) - (AW+1)'(idx);
  assign rd_addr = (addr_sum >= DEPTH_W) ? AW'(addr_sum - DEPTH_W) : addr_sum[AW-1:0];

  assign len_sum  = 14'(prompt_r) + 14'(acc_r) + 14'd1;
  assign len_stop = (len_sum >= {1'b0, ctx_r}) || (acc_r >= maxg_r);
  assign speech   = !tok_r[TokW-1] && (tok_r[HistW-1:0] >= SPEECH_LOW)
                    && (tok_r[HistW-1:0] <= SPEECH_HIGH);
  assign is_end   = endf_r || (!tok_r[TokW-1] && (tok_r[HistW-1:0] == END_ID_A
                    || tok_r[HistW-1:0] == END_ID_B || tok_r[HistW-1:0] == END_ID_C));
  assign eq_prev  = (tok_r == prev_r);
  assign run_nxt  = eq_prev ? ((run_r < RUN_SAT) ? run_r + 3'd1 : run_r) : 3'd0;
  assign cmp_eq   = (rdata_r == v_r);
  assign dnew     = dcnt_r + {6'd0, !match_r};

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_stop = !out_acc_r;
  assign out_stop_reason = out_rsn_r;
  assign out_generated_count = out_cnt_r;

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (state_r == S_WRITE) begin
      mem[head_r] <= tok_r[HistW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      prompt_r <= '0;
      ctx_r <= 13'd4096;
      maxg_r <= 13'd4096;
      acc_r <= '0;
      head_r <= '0;
      prev_r <= '1;
      run_r <= '0;
      over_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROMPT:  prompt_r <= cfg_wdata[11:0];
          CFG_CONTEXT: ctx_r <= cfg_wdata;
          CFG_MAXGEN:  maxg_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            tok_r <= in_token_id;
            endf_r <= in_vocab_end_flag;
            if (in_new_sequence) begin
              acc_r <= '0;
              head_r <= '0;
              prev_r <= '1;
              run_r <= '0;
              over_r <= 1'b0;
            end
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_acc_r <= 1'b0;
          state_r <= S_DONE;
          if (over_r) begin
            res_rsn_r <= RSN_OVER;
          end else if (len_stop) begin
            res_rsn_r <= RSN_LENGTH;
            over_r <= 1'b1;
          end else if (tok_r == -19'sd1) begin
            res_rsn_r <= RSN_NULL;
            over_r <= 1'b1;
          end else if (is_end || !speech) begin
            res_rsn_r <= RSN_END;
            over_r <= 1'b1;
          end else begin
            run_r <= run_nxt;
            prev_r <= tok_r;
            if (run_nxt > MAX_RUN) begin
              res_rsn_r <= RSN_REPEAT;
              over_r <= 1'b1;
            end else if (acc_r >= 13'(LOOP_WINDOW)) begin
              ph_r <= PH_LOOP;
              i_r <= '0;
              dcnt_r <= '0;
              state_r <= S_OUT_RD;
            end else begin
              state_r <= S_WRITE;
            end
          end
        end
        S_OUT_RD: state_r <= S_OUT_LAT;
        S_OUT_LAT: begin
          v_r <= rdata_r;
          j_r <= '0;
          cnt_r <= '0;
          match_r <= 1'b0;
          state_r <= (ph_r != PH_DOM && i_r == 7'd0) ? S_OUT_END : S_IN_RD;
        end
        S_IN_RD: state_r <= S_IN_CMP;
        S_IN_CMP: begin
          j_r <= j_r + 7'd1;
          if (ph_r == PH_DOM) begin
            if (cmp_eq) cnt_r <= cnt_r + 5'd1;
            state_r <= (j_r == win - 7'd1) ? S_OUT_END : S_IN_RD;
          end else if (cmp_eq) begin
            match_r <= 1'b1;
            state_r <= S_OUT_END;
          end else begin
            state_r <= (j_r + 7'd1 == i_r) ? S_OUT_END : S_IN_RD;
          end
        end
        S_OUT_END: begin
          dcnt_r <= dnew;
          i_r <= i_r + 7'd1;
          state_r <= S_OUT_RD;
          if (ph_r == PH_DOM && cnt_r > DOM_LIMIT) begin
            res_acc_r <= 1'b0;
            res_rsn_r <= RSN_DOM;
            over_r <= 1'b1;
            state_r <= S_DONE;
          end else if (i_r == win - 7'd1) begin
            if (ph_r == PH_LOOP && dnew <= LOOP_MAX_DISTINCT) begin
              res_acc_r <= 1'b0;
              res_rsn_r <= RSN_LOOP;
              over_r <= 1'b1;
              state_r <= S_DONE;
            end else if (ph_r == PH_DIV && dnew < DIV_MIN_DISTINCT) begin
              res_acc_r <= 1'b0;
              res_rsn_r <= RSN_DIV;
              over_r <= 1'b1;
              state_r <= S_DONE;
            end else if (ph_r != PH_DIV && acc_r >= 13'(ph_win(ph_r + 2'd1))) begin
              ph_r <= ph_r + 2'd1;
              i_r <= '0;
              dcnt_r <= '0;
            end else begin
              state_r <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          head_r <= (head_r == AW'(HISTORY_DEPTH - 1)) ? '0 : head_r + AW'(1);
          if (acc_r != '1) acc_r <= acc_r + 13'd1;
          res_acc_r <= 1'b1;
          res_rsn_r <= RSN_NONE;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_acc_r <= res_acc_r;
            out_rsn_r <= res_rsn_r;
            out_cnt_r <= acc_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
